@@ sv/shra_pkg.sv @@
// Shared types, codes and constants of the segment hit rate accumulator.
// No dependencies; every other file of the block imports this package.
package shra_pkg;

   // Default values of the top-level parameters.
   localparam int TIME_BINS_DEFAULT = 16;
   localparam int LAYERS_DEFAULT = 4;
   localparam int LADDERS_DEFAULT = 16;
   localparam int SENSORS_DEFAULT = 5;
   localparam int COUNTER_WIDTH_DEFAULT = 48;

   // Port field widths.
   localparam int ACTION_W = 2;
   localparam int BIN_PORT_W = 4;
   localparam int PRESENT_W = 2;
   localparam int LAYER_W = 2;
   localparam int LADDER_W = 4;
   localparam int SENSOR_W = 3;
   localparam int CHARGE_W = 20;
   localparam int CAT_W = 2;
   localparam int SEGMENT_W = 7;
   localparam int VALUE_W = 48;

   // The innermost layer keeps a small ladder by sensor map of its own.
   localparam int INNER_LADDERS = 7;
   localparam int INNER_SENSORS = 2;
   localparam int CATEGORIES = 4;

   // Back end sequencing: a hit touches up to five counters per category.
   localparam int HIT_STEPS = 5;
   localparam int STEP_W = 4;

   localparam int JOB_QUEUE_DEPTH = 4;
   localparam int RSP_DEPTH = 2;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Item actions.
   localparam logic [ACTION_W-1:0] ACT_EVENT = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_DIGIT = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLUSTER = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd3;

   // Counter categories.
   localparam logic [CAT_W-1:0] CAT_DIGIT = 2'd0;
   localparam logic [CAT_W-1:0] CAT_HIGH = 2'd1;
   localparam logic [CAT_W-1:0] CAT_LOW = 2'd2;
   localparam logic [CAT_W-1:0] CAT_USUM = 2'd3;

   // Counter operations of the back end.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SET = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // Counters touched by one hit, in the order the back end visits them.
   localparam logic [STEP_W-1:0] SUB_LAYER = 4'd0;
   localparam logic [STEP_W-1:0] SUB_LADDER = 4'd1;
   localparam logic [STEP_W-1:0] SUB_SENSOR = 4'd2;
   localparam logic [STEP_W-1:0] SUB_TOTAL = 4'd3;
   localparam logic [STEP_W-1:0] SUB_INNER = 4'd4;

   // Segment layout inside one bin and category.
   function automatic int seg_ladder_base(int layers);
      return layers;
   endfunction

   function automatic int seg_sensor_base(int layers, int ladders);
      return layers + layers * ladders;
   endfunction

   function automatic int seg_total(int layers, int ladders, int sensors);
      return layers * (1 + ladders + sensors);
   endfunction

   function automatic int seg_inner(int layers, int ladders, int sensors);
      return seg_total(layers, ladders, sensors) + 1;
   endfunction

   function automatic int seg_events(int layers, int ladders, int sensors);
      return seg_inner(layers, ladders, sensors) + INNER_LADDERS * INNER_SENSORS;
   endfunction

   function automatic int seg_valid(int layers, int ladders, int sensors);
      return seg_events(layers, ladders, sensors) + 1;
   endfunction

   function automatic int seg_count(int layers, int ladders, int sensors);
      return seg_valid(layers, ladders, sensors) + 1;
   endfunction

   // One unit of work for the back end.
   typedef struct packed {
      logic [ACTION_W-1:0] kind;
      logic [BIN_PORT_W-1:0] bin;
      logic digits;
      logic clusters;
      logic [LAYER_W-1:0] layer;
      logic [LADDER_W-1:0] ladder;
      logic [SENSOR_W-1:0] sensor;
      logic high;
      logic u_side;
      logic [CHARGE_W-1:0] charge;
      logic [CAT_W-1:0] cat;
      logic [SEGMENT_W-1:0] seg;
      logic clear;
      logic read_ok;
   } job_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } back_status_type;

endpackage

@@ sv/shra_front.sv @@
// Front end: takes input items, tracks the open event and classifies each item
// into a job for the back end. Holds the charge threshold register. Uses shra_pkg.
module shra_front #(
   parameter int TIME_BINS = shra_pkg::TIME_BINS_DEFAULT,
   parameter int LAYERS = shra_pkg::LAYERS_DEFAULT,
   parameter int LADDERS = shra_pkg::LADDERS_DEFAULT,
   parameter int SENSORS = shra_pkg::SENSORS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic accept,
   input logic [shra_pkg::ACTION_W-1:0] action,
   input logic [shra_pkg::BIN_PORT_W-1:0] time_bin,
   input logic event_accepted,
   input logic [shra_pkg::PRESENT_W-1:0] data_present,
   input logic [shra_pkg::LAYER_W-1:0] layer_index,
   input logic [shra_pkg::LADDER_W-1:0] ladder_index,
   input logic [shra_pkg::SENSOR_W-1:0] sensor_index,
   input logic [shra_pkg::CHARGE_W-1:0] cluster_charge,
   input logic is_u_side,
   input logic [shra_pkg::CAT_W-1:0] read_category,
   input logic [shra_pkg::SEGMENT_W-1:0] read_segment,
   input logic clear_after_read,
   input logic csr_write,
   input logic [shra_pkg::CHARGE_W-1:0] csr_data,
   output logic job_push,
   output shra_pkg::job_type job
);
   import shra_pkg::*;

   localparam int SEGMENTS = seg_count(LAYERS, LADDERS, SENSORS);

   logic [CHARGE_W-1:0] threshold_ff, threshold_in;
   logic [BIN_PORT_W-1:0] cur_bin_ff, cur_bin_in;
   logic event_open_ff, event_open_in;
   logic digits_open_ff, digits_open_in;
   logic clusters_open_ff, clusters_open_in;
   logic bin_ok, pos_ok, seg_ok;

   always_comb begin
      bin_ok = 32'(time_bin) < TIME_BINS;
      pos_ok = (32'(layer_index) < LAYERS) && (32'(ladder_index) < LADDERS)
               && (32'(sensor_index) < SENSORS);
      seg_ok = 32'(read_segment) < SEGMENTS;

      threshold_in = csr_write ? csr_data : threshold_ff;
      cur_bin_in = cur_bin_ff;
      event_open_in = event_open_ff;
      digits_open_in = digits_open_ff;
      clusters_open_in = clusters_open_ff;
      job_push = 1'b0;

      job.kind = action;
      job.bin = ((action == ACT_EVENT) || (action == ACT_READ)) ? time_bin : cur_bin_ff;
      job.digits = data_present[0];
      job.clusters = data_present[1];
      job.layer = layer_index;
      job.ladder = ladder_index;
      job.sensor = sensor_index;
      job.high = cluster_charge > threshold_ff;
      job.u_side = is_u_side;
      job.charge = cluster_charge;
      job.cat = read_category;
      job.seg = read_segment;
      job.clear = clear_after_read;
      job.read_ok = bin_ok && seg_ok;

      if (accept) begin
         unique case (action)
            ACT_EVENT: begin
               event_open_in = 1'b0;
               digits_open_in = 1'b0;
               clusters_open_in = 1'b0;
               if (event_accepted && bin_ok) begin
                  cur_bin_in = time_bin;
                  event_open_in = 1'b1;
                  digits_open_in = data_present[0];
                  clusters_open_in = data_present[1];
                  // An event without data marks only opens; nothing to count.
                  job_push = |data_present;
               end
            end
            ACT_DIGIT: begin
               job_push = event_open_ff && digits_open_ff && pos_ok;
            end
            ACT_CLUSTER: begin
               job_push = event_open_ff && clusters_open_ff && pos_ok;
            end
            ACT_READ: begin
               job_push = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         cur_bin_ff <= '0;
         event_open_ff <= 1'b0;
         digits_open_ff <= 1'b0;
         clusters_open_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         cur_bin_ff <= cur_bin_in;
         event_open_ff <= event_open_in;
         digits_open_ff <= digits_open_in;
         clusters_open_ff <= clusters_open_in;
      end
   end

endmodule

@@ sv/shra_job_queue.sv @@
// Short job queue between the front end and the back end.
// Uses job_type and JOB_QUEUE_DEPTH from shra_pkg.
module shra_job_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input shra_pkg::job_type item,
   input logic pop,
   output logic full,
   output logic empty,
   output shra_pkg::job_type head
);
   import shra_pkg::*;

   localparam int PTR_W = $clog2(JOB_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);

   job_type slots_ff [JOB_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      full = count_ff == CNT_W'(JOB_QUEUE_DEPTH);
      empty = count_ff == '0;
      head = slots_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

@@ sv/shra_back.sv @@
// Back end: counter memory, clearing pass, job sequencer and the saturating
// read-modify-write stage. Uses the codes, layout functions and types of shra_pkg.
module shra_back #(
   parameter int TIME_BINS = shra_pkg::TIME_BINS_DEFAULT,
   parameter int LAYERS = shra_pkg::LAYERS_DEFAULT,
   parameter int LADDERS = shra_pkg::LADDERS_DEFAULT,
   parameter int SENSORS = shra_pkg::SENSORS_DEFAULT,
   parameter int COUNTER_WIDTH = shra_pkg::COUNTER_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic q_empty,
   input shra_pkg::job_type q_head,
   output logic q_pop,
   input logic [shra_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic rsp_push,
   output logic [shra_pkg::VALUE_W-1:0] rsp_value,
   output shra_pkg::back_status_type status
);
   import shra_pkg::*;

   localparam int SEGMENTS = seg_count(LAYERS, LADDERS, SENSORS);
   localparam int SEG_W = $clog2(SEGMENTS);
   // The bin port is four bits wide, so no more than sixteen bins are reachable.
   localparam int BINS_USED = (TIME_BINS < (1 << BIN_PORT_W)) ? TIME_BINS : (1 << BIN_PORT_W);
   localparam int BIN_W = (BINS_USED > 1) ? $clog2(BINS_USED) : 1;
   localparam int ADDR_W = BIN_W + CAT_W + SEG_W;
   localparam int DEPTH = 1 << ADDR_W;
   localparam int SUM_W = ((COUNTER_WIDTH > CHARGE_W) ? COUNTER_WIDTH : CHARGE_W) + 1;
   localparam logic [COUNTER_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = '1;

   // Event jobs walk two steps per category: event count, then valid mark.
   localparam logic [STEP_W-1:0] EVENT_FIRST_CLUSTER = STEP_W'(2);
   localparam logic [STEP_W-1:0] EVENT_LAST_DIGIT = STEP_W'(1);
   localparam logic [STEP_W-1:0] EVENT_LAST = STEP_W'(2 * CATEGORIES - 1);
   localparam logic [STEP_W-1:0] HIT_LAST = STEP_W'(HIT_STEPS - 1);
   localparam logic [STEP_W-1:0] HIT_LAST_OUTER = STEP_W'(HIT_STEPS - 2);
   localparam logic [STEP_W-1:0] CLUSTER_USUM_FIRST = STEP_W'(HIT_STEPS);
   localparam logic [STEP_W-1:0] CLUSTER_LAST = STEP_W'(2 * HIT_STEPS - 1);

   logic [COUNTER_WIDTH-1:0] counter_mem [DEPTH];

   logic clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic busy_ff, busy_in;
   job_type job_ff, job_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CAT_W-1:0] op_cat;
   logic [SEG_W-1:0] op_seg;
   logic [STEP_W-1:0] op_sub;
   logic op_is_hit;
   logic [1:0] op_kind;
   logic [CHARGE_W-1:0] op_amount;
   logic op_en;
   logic [STEP_W-1:0] last_step;
   logic [STEP_W-1:0] first_step;
   logic inner_ok;
   logic [ADDR_W-1:0] op_addr;
   logic space_ok, issue, b_read_pending;

   logic b_valid_ff, b_valid_in;
   logic [1:0] b_kind_ff;
   logic [ADDR_W-1:0] b_addr_ff;
   logic [CHARGE_W-1:0] b_amount_ff;
   logic b_en_ff;
   logic b_clear_ff;
   logic fwd_ff, fwd_in;
   logic [COUNTER_WIDTH-1:0] fwd_data_ff;
   logic [COUNTER_WIDTH-1:0] rd_data_ff;

   logic [COUNTER_WIDTH-1:0] cur_data, new_data;
   logic [SUM_W-1:0] sum;
   logic b_write;
   logic wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [COUNTER_WIDTH-1:0] wr_data;

   // Current step of the job in hand -> one counter operation.
   always_comb begin
      inner_ok = (job_ff.layer == '0) && (32'(job_ff.ladder) < INNER_LADDERS)
                 && (32'(job_ff.sensor) < INNER_SENSORS);
      op_cat = CAT_DIGIT;
      op_seg = '0;
      op_sub = step_ff;
      op_is_hit = 1'b0;
      op_kind = OP_ADD;
      op_amount = CHARGE_W'(1);
      op_en = 1'b1;
      last_step = '0;

      unique case (job_ff.kind)
         ACT_EVENT: begin
            op_cat = step_ff[2:1];
            if (step_ff[0]) begin
               op_seg = SEG_W'(seg_valid(LAYERS, LADDERS, SENSORS));
               op_kind = OP_SET;
            end else begin
               op_seg = SEG_W'(seg_events(LAYERS, LADDERS, SENSORS));
            end
            last_step = job_ff.clusters ? EVENT_LAST : EVENT_LAST_DIGIT;
         end
         ACT_DIGIT: begin
            op_is_hit = 1'b1;
            last_step = inner_ok ? HIT_LAST : HIT_LAST_OUTER;
         end
         ACT_CLUSTER: begin
            op_is_hit = 1'b1;
            if (step_ff < CLUSTER_USUM_FIRST) begin
               op_cat = job_ff.high ? CAT_HIGH : CAT_LOW;
            end else begin
               op_cat = CAT_USUM;
               op_sub = step_ff - CLUSTER_USUM_FIRST;
               op_amount = job_ff.charge;
            end
            last_step = job_ff.u_side ? CLUSTER_LAST : HIT_LAST;
         end
         ACT_READ: begin
            op_cat = job_ff.cat;
            op_seg = SEG_W'(32'(job_ff.seg));
            op_kind = OP_READ;
            op_en = job_ff.read_ok;
         end
      endcase

      if (op_is_hit) begin
         unique case (op_sub)
            SUB_LAYER: op_seg = SEG_W'(32'(job_ff.layer));
            SUB_LADDER: op_seg = SEG_W'(seg_ladder_base(LAYERS)
                                        + 32'(job_ff.layer) * LADDERS + 32'(job_ff.ladder));
            SUB_SENSOR: op_seg = SEG_W'(seg_sensor_base(LAYERS, LADDERS)
                                        + 32'(job_ff.layer) * SENSORS + 32'(job_ff.sensor));
            SUB_TOTAL: op_seg = SEG_W'(seg_total(LAYERS, LADDERS, SENSORS));
            SUB_INNER: begin
               op_seg = SEG_W'(seg_inner(LAYERS, LADDERS, SENSORS)
                               + 32'(job_ff.ladder) * INNER_SENSORS + 32'(job_ff.sensor));
               // Every cluster walks the inner step, also in the U-side sum category, even
               // when the hit lies outside the inner map; it then writes nothing.
               op_en = inner_ok;
            end
            default: op_seg = '0;
         endcase
      end

      op_addr = {BIN_W'(job_ff.bin), op_cat, op_seg};
   end

   // Sequencer control.
   always_comb begin
      b_read_pending = b_valid_ff && (b_kind_ff == OP_READ);
      // Room must be reserved for the read already in the write stage.
      space_ok = (32'(rsp_count) + 32'(b_read_pending)) < RSP_DEPTH;
      issue = busy_ff && !clearing_ff && ((op_kind != OP_READ) || space_ok);
      q_pop = !busy_ff && !clearing_ff && !q_empty;
      first_step = ((q_head.kind == ACT_EVENT) && !q_head.digits) ? EVENT_FIRST_CLUSTER : '0;

      busy_in = busy_ff;
      step_in = step_ff;
      job_in = job_ff;
      if (q_pop) begin
         busy_in = 1'b1;
         step_in = first_step;
         job_in = q_head;
      end else if (issue) begin
         step_in = step_ff + STEP_W'(1);
         if (step_ff == last_step) begin
            busy_in = 1'b0;
         end
      end

      clr_addr_in = clearing_ff ? clr_addr_ff + ADDR_W'(1) : clr_addr_ff;
      clearing_in = clearing_ff && (clr_addr_ff != LAST_ADDR);
      b_valid_in = issue;
   end

   // Write stage: saturating add, valid-mark set, or read with optional clear, of the counter read in the cycle before.
   always_comb begin
      cur_data = fwd_ff ? fwd_data_ff : rd_data_ff;
      sum = SUM_W'(cur_data) + SUM_W'(b_amount_ff);
      unique case (b_kind_ff)
         OP_ADD: new_data = (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : COUNTER_WIDTH'(sum);
         OP_SET: new_data = COUNTER_WIDTH'(1);
         OP_READ: new_data = '0;
         default: new_data = '0;
      endcase
      b_write = b_valid_ff && b_en_ff && ((b_kind_ff != OP_READ) || b_clear_ff);

      if (clearing_ff) begin
         wr_en = 1'b1;
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else begin
         wr_en = b_write;
         wr_addr = b_addr_ff;
         wr_data = new_data;
      end

      // The memory returns the old word when read and written at one address.
      fwd_in = issue && b_write && (op_addr == b_addr_ff);

      rsp_push = b_read_pending;
      rsp_value = b_en_ff ? VALUE_W'(cur_data) : '0;
      status.clearing = clearing_ff;
      status.busy = busy_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         counter_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= counter_mem[op_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         busy_ff <= 1'b0;
         step_ff <= '0;
         b_valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         busy_ff <= busy_in;
         step_ff <= step_in;
         b_valid_ff <= b_valid_in;
         fwd_ff <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      fwd_data_ff <= new_data;
      if (issue) begin
         b_kind_ff <= op_kind;
         b_addr_ff <= op_addr;
         b_amount_ff <= op_amount;
         b_en_ff <= op_en;
         b_clear_ff <= job_ff.clear;
      end
   end

endmodule

@@ sv/shra_rsp_fifo.sv @@
// Result queue in front of the output ports; two entries deep.
// Uses VALUE_W, RSP_DEPTH and RSP_CNT_W from shra_pkg.
module shra_rsp_fifo (
   input logic clock,
   input logic reset,
   input logic push,
   input logic [shra_pkg::VALUE_W-1:0] value,
   input logic pop,
   output logic empty,
   output logic [shra_pkg::RSP_CNT_W-1:0] count,
   output logic [shra_pkg::VALUE_W-1:0] head
);
   import shra_pkg::*;

   localparam int PTR_W = $clog2(RSP_DEPTH);

   logic [VALUE_W-1:0] slots_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic do_pop;

   always_comb begin
      empty = count_ff == '0;
      count = count_ff;
      head = slots_ff[rd_ptr_ff];
      do_pop = pop && !empty;
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + RSP_CNT_W'(push) - RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= value;
      end
   end

endmodule

@@ sv/segment_hit_rate_accumulator.sv @@
// Segment hit rate accumulator: per-time-bin histograms of detector hits in four
// categories (digits, high-charge clusters, low-charge clusters, U-side charge sum),
// kept as saturating counters in one memory of 2^(bin bits + 2 + segment bits) words.
// After reset a clearing pass zeroes that memory, one word a cycle; req_full stays
// high meanwhile, while csr writes are taken. The front end takes one item per
// cycle while req_full is low and queues a job for every item that touches the
// counters. The back end loads a job from the job queue only when idle and then
// visits its counters one after another, in the order its steps set, through the
// single read-modify-write path into the counter memory. Ignored items and event
// starts without data queue no job. A read's counter passes from the back-end step
// through the write stage into a two-deep result queue in front of the result
// ports; a full result queue holds the back end's read steps.
module segment_hit_rate_accumulator #(
   parameter int TIME_BINS = shra_pkg::TIME_BINS_DEFAULT,
   parameter int LAYERS = shra_pkg::LAYERS_DEFAULT,
   parameter int LADDERS = shra_pkg::LADDERS_DEFAULT,
   parameter int SENSORS = shra_pkg::SENSORS_DEFAULT,
   parameter int COUNTER_WIDTH = shra_pkg::COUNTER_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [shra_pkg::ACTION_W-1:0] req_action,
   input logic [shra_pkg::BIN_PORT_W-1:0] req_time_bin,
   input logic req_event_accepted,
   input logic [shra_pkg::PRESENT_W-1:0] req_data_present,
   input logic [shra_pkg::LAYER_W-1:0] req_layer_index,
   input logic [shra_pkg::LADDER_W-1:0] req_ladder_index,
   input logic [shra_pkg::SENSOR_W-1:0] req_sensor_index,
   input logic [shra_pkg::CHARGE_W-1:0] req_cluster_charge,
   input logic req_is_u_side,
   input logic [shra_pkg::CAT_W-1:0] req_read_category,
   input logic [shra_pkg::SEGMENT_W-1:0] req_read_segment,
   input logic req_clear_after_read,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic [shra_pkg::VALUE_W-1:0] rsp_counter_value,
   input logic csr_valid,
   output logic csr_ready,
   input logic [shra_pkg::CHARGE_W-1:0] csr_charge_threshold
);
   import shra_pkg::*;

   logic accept;
   logic job_push;
   job_type job;
   logic q_full, q_empty, q_pop;
   job_type q_head;
   back_status_type back_st;
   logic rsp_push;
   logic [VALUE_W-1:0] rsp_value;
   logic [RSP_CNT_W-1:0] rsp_count;

   assign req_full = back_st.clearing || q_full;
   assign accept = req_push && !req_full;
   assign csr_ready = 1'b1;

   shra_front #(
      .TIME_BINS(TIME_BINS),
      .LAYERS(LAYERS),
      .LADDERS(LADDERS),
      .SENSORS(SENSORS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .action(req_action),
      .time_bin(req_time_bin),
      .event_accepted(req_event_accepted),
      .data_present(req_data_present),
      .layer_index(req_layer_index),
      .ladder_index(req_ladder_index),
      .sensor_index(req_sensor_index),
      .cluster_charge(req_cluster_charge),
      .is_u_side(req_is_u_side),
      .read_category(req_read_category),
      .read_segment(req_read_segment),
      .clear_after_read(req_clear_after_read),
      .csr_write(csr_valid && csr_ready),
      .csr_data(csr_charge_threshold),
      .job_push(job_push),
      .job(job)
   );

   shra_job_queue u_job_queue (
      .clock(clock),
      .reset(reset),
      .push(job_push),
      .item(job),
      .pop(q_pop),
      .full(q_full),
      .empty(q_empty),
      .head(q_head)
   );

   shra_back #(
      .TIME_BINS(TIME_BINS),
      .LAYERS(LAYERS),
      .LADDERS(LADDERS),
      .SENSORS(SENSORS),
      .COUNTER_WIDTH(COUNTER_WIDTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_empty(q_empty),
      .q_head(q_head),
      .q_pop(q_pop),
      .rsp_count(rsp_count),
      .rsp_push(rsp_push),
      .rsp_value(rsp_value),
      .status(back_st)
   );

   shra_rsp_fifo u_rsp_fifo (
      .clock(clock),
      .reset(reset),
      .push(rsp_push),
      .value(rsp_value),
      .pop(rsp_pop),
      .empty(rsp_empty),
      .count(rsp_count),
      .head(rsp_counter_value)
   );

`ifndef NO_ASSERTIONS
   // The front end only queues jobs for accepted items, which need queue room.
   a_job_queue_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !q_full)
      else $error("job queued while the job queue is full");

   // No job may reach the back end before the clearing pass has finished.
   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      back_st.clearing |-> (!back_st.busy && q_empty))
      else $error("job in flight during the clearing pass");

   // The back end reserves result room before it issues a read.
   a_result_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (32'(rsp_count) < RSP_DEPTH))
      else $error("result pushed into a full result queue");
`endif

endmodule
